FILE: hdl/ascr_pkg.sv
// Shared types, character codes and CRC/character helper functions for the record checker.
package ascr_pkg;

    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] LOW24_MASK = 32'h00FFFFFF;
    localparam logic [7:0]  STAR_CHAR  = 8'h2A;
    localparam logic [7:0]  HASH_CHAR  = 8'h23;
    localparam logic [7:0]  NUL_CHAR   = 8'h00;
    localparam logic [7:0]  SPACE_CHAR = 8'h20;
    localparam logic [3:0]  HEX_DIGITS = 4'd8;
    localparam int          TDATA_OUT_W = 72;

    typedef enum logic [1:0] {
        FAULT_NONE      = 2'd0,
        FAULT_NO_STAR   = 2'd1,
        FAULT_MALFORMED = 2'd2,
        FAULT_MISMATCH  = 2'd3
    } fault_t;

    typedef struct packed {
        logic [31:0] received_crc;
        logic [31:0] computed_crc;
        fault_t      fault;
        logic        checksum_ok;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] low;
        low = {24'd0, crc[7:0] ^ b};
        for (int k = 0; k < 8; k++)
        begin
            if (low[0])
                low = (low >> 1) ^ CRC_POLY;
            else
                low = low >> 1;
        end
        return ((crc >> 8) & LOW24_MASK) ^ low;
    endfunction

    // Bit 4 set means the byte is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'd16;
        if (b inside {[8'h30:8'h39]})
            v = 5'(b - 8'h30);
        else if (b inside {[8'h41:8'h46]})
            v = 5'(b - 8'h41 + 8'd10);
        else if (b inside {[8'h61:8'h66]})
            v = 5'(b - 8'h61 + 8'd10);
        return v;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == SPACE_CHAR) || (b inside {[8'h09:8'h0D]});
    endfunction

endpackage

FILE: hdl/ascr_core.sv
// Record state, CRC update and checksum tail parser for one byte per step.
module ascr_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    output ascr_pkg::result_t result
);
    import ascr_pkg::*;

    logic [31:0] running_crc_reg, running_crc_next;
    logic [31:0] crc_at_star_reg, crc_at_star_next;
    logic [31:0] hex_acc_reg, hex_acc_next;
    logic [3:0]  digit_count_reg, digit_count_next;
    logic        star_seen_reg, star_seen_next;
    logic        space_seen_reg, space_seen_next;
    logic        tail_broken_reg, tail_broken_next;
    logic        at_start_reg, at_start_next;

    logic        skip;
    logic [4:0]  hv;

    always_comb
    begin
        running_crc_next = running_crc_reg;
        crc_at_star_next = crc_at_star_reg;
        hex_acc_next     = hex_acc_reg;
        digit_count_next = digit_count_reg;
        star_seen_next   = star_seen_reg;
        space_seen_next  = space_seen_reg;
        tail_broken_next = tail_broken_reg;
        at_start_next    = 1'b0;
        skip             = at_start_reg && (data_byte == HASH_CHAR);
        hv               = hex_value(data_byte);
        result           = '0;

        if (!skip)
        begin
            if (data_byte == STAR_CHAR)
            begin
                crc_at_star_next = running_crc_reg;
                star_seen_next   = 1'b1;
                hex_acc_next     = '0;
                digit_count_next = '0;
                space_seen_next  = 1'b0;
                tail_broken_next = 1'b0;
            end
            else if (star_seen_reg && !tail_broken_reg)
            begin
                if (!hv[4])
                begin
                    if (space_seen_reg || (digit_count_reg >= HEX_DIGITS))
                        tail_broken_next = 1'b1;
                    else
                    begin
                        hex_acc_next     = {hex_acc_reg[27:0], hv[3:0]};
                        digit_count_next = digit_count_reg + 4'd1;
                    end
                end
                else if (is_blank(data_byte))
                begin
                    if (digit_count_reg < HEX_DIGITS)
                        tail_broken_next = 1'b1;
                    else
                        space_seen_next = 1'b1;
                end
                else if (!((data_byte == NUL_CHAR) && last_byte
                           && (digit_count_reg >= HEX_DIGITS)))
                    tail_broken_next = 1'b1;
            end
            running_crc_next = crc_byte(running_crc_reg, data_byte);
        end

        if (!star_seen_next)
            result.fault = FAULT_NO_STAR;
        else
        begin
            result.computed_crc = crc_at_star_next;
            if (tail_broken_next || (digit_count_next != HEX_DIGITS))
                result.fault = FAULT_MALFORMED;
            else
            begin
                result.received_crc = hex_acc_next;
                result.fault = (hex_acc_next == crc_at_star_next) ? FAULT_NONE
                                                                  : FAULT_MISMATCH;
            end
        end
        result.checksum_ok = (result.fault == FAULT_NONE);

        if (last_byte)
        begin
            running_crc_next = '0;
            crc_at_star_next = '0;
            hex_acc_next     = '0;
            digit_count_next = '0;
            star_seen_next   = 1'b0;
            space_seen_next  = 1'b0;
            tail_broken_next = 1'b0;
            at_start_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_crc_reg <= '0;
            crc_at_star_reg <= '0;
            hex_acc_reg     <= '0;
            digit_count_reg <= '0;
            star_seen_reg   <= 1'b0;
            space_seen_reg  <= 1'b0;
            tail_broken_reg <= 1'b0;
            at_start_reg    <= 1'b1;
        end
        else if (step)
        begin
            running_crc_reg <= running_crc_next;
            crc_at_star_reg <= crc_at_star_next;
            hex_acc_reg     <= hex_acc_next;
            digit_count_reg <= digit_count_next;
            star_seen_reg   <= star_seen_next;
            space_seen_reg  <= space_seen_next;
            tail_broken_reg <= tail_broken_next;
            at_start_reg    <= at_start_next;
        end
    end

endmodule

FILE: hdl/ascii_record_crc32_checker.sv
// Top level of the ASCII record CRC-32 checker with its stream ports.
//
// Usage: record bytes enter on the s_ group, one byte per transaction, with
// s_tlast high on the final byte of the record. A leading hash is skipped and
// every other byte enters a reflected CRC-32 that starts from zero. For each
// record exactly one result transaction leaves on the m_ group after its last
// byte, carrying the pass flag, the fault code, the CRC captured at the final
// star and the value of the eight hex digits that follow it.
// Datapath: a byte is held in the input register, then the state update and
// the result are computed in one pass into the output register, which offers it.
// Throughput: one byte per cycle through the byte-wide CRC update, except
// while a last byte waits until the pending result has been taken.
// Reset empties both registers and clears the record state, so the next byte
// is taken as the first byte of a new record. When the receiver stalls, the
// result waits in the output register while bytes that give no result keep
// flowing; only a further last byte waits until the pending result has been
// taken.
module ascii_record_crc32_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [ascr_pkg::TDATA_OUT_W-1:0] m_tdata
    // m_tdata: checksum_ok[0], fault[2:1], computed_crc[34:3],
    // received_crc[66:35], zero padding[71:67]
);
    import ascr_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    result_t    out_result_reg;
    result_t    result;
    logic       advance;

    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(TDATA_OUT_W - RESULT_W)'(0), out_result_reg};

    ascr_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance && in_last_reg)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && in_last_reg)
            out_result_reg <= result;
    end

endmodule

FILE: hdl/ascr_checker.sv
// Port-level assertions for the record checker and the bind that attaches them.
module ascr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [ascr_pkg::TDATA_OUT_W-1:0] m_tdata
);
    import ascr_pkg::*;

    // The pass flag agrees with the fault code.
    a_ok_matches_fault: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] == FAULT_NONE)))
        else $error("checksum_ok disagrees with fault");

    // A record without a star reports both CRC values as zero.
    a_no_star_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[2:1] == FAULT_NO_STAR)) |->
            ((m_tdata[34:3] == 32'd0) && (m_tdata[66:35] == 32'd0)))
        else $error("no-star result carries a CRC value");

    // A malformed tail reports no received value; a mismatch has unequal values and a pass equal ones.
    a_tail_values: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |->
            (((m_tdata[2:1] != FAULT_MALFORMED) || (m_tdata[66:35] == 32'd0)) &&
             ((m_tdata[2:1] != FAULT_MISMATCH) || (m_tdata[66:35] != m_tdata[34:3])) &&
             ((m_tdata[2:1] != FAULT_NONE) || (m_tdata[66:35] == m_tdata[34:3]))))
        else $error("received CRC inconsistent with fault");

    // A stalled result transaction is held unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

endmodule

bind ascii_record_crc32_checker ascr_checker u_ascr_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: verif/tb.sv
// Self-checking testbench for the ASCII record CRC-32 checker: directed and random records.
`timescale 1ns / 1ps

module tb;

    import ascr_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int errors = 0;
    int bytes_sent = 0;
    int cycles = 0;

    logic [31:0] crc_run = 32'd0;
    logic [31:0] crc_star = 32'd0;
    logic [31:0] hex_acc = 32'd0;
    int          n_digits = 0;
    logic        got_star = 1'b0;
    logic        got_blank = 1'b0;
    logic        tail_bad = 1'b0;
    logic        first_byte = 1'b1;

    result_t     expected_results[$];
    result_t     want;
    result_t     got;
    logic [7:0]  rec_bytes[$];

    ascii_record_crc32_checker uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] d);
        logic [31:0] r;
        r = c ^ {24'd0, d};
        for (int i = 0; i < 8; i++)
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    function automatic logic [4:0] digit_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return {1'b0, c[3:0]};
        if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            return {1'b0, c[3:0] + 4'd9};
        return 5'd16;
    endfunction

    function automatic logic is_blank_char(input logic [7:0] c);
        return (c == SPACE_CHAR) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
        if (v < 4'd10)
            return 8'h30 + {4'd0, v};
        return (upper ? 8'h41 : 8'h61) + {4'd0, v} - 8'd10;
    endfunction

    function automatic logic [7:0] blank_char(input int k);
        if (k == 0)
            return SPACE_CHAR;
        return 8'(8'h09 + k - 1);
    endfunction

    function automatic logic [7:0] pick_byte();
        int k;
        k = $urandom_range(9);
        case (k)
            0: return STAR_CHAR;
            1: return HASH_CHAR;
            2: return hex_char(4'($urandom_range(15)), 1'($urandom_range(1)));
            3: return blank_char($urandom_range(5));
            4: return NUL_CHAR;
            5:
            begin
                k = $urandom_range(2);
                return (k == 0) ? 8'h2B : ((k == 1) ? 8'h2D : 8'h78);
            end
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic append_byte(input logic [7:0] c);
        rec_bytes.insert(rec_bytes.size(), c);
    endtask

    task automatic clear_record_state();
        crc_run = 32'd0;
        crc_star = 32'd0;
        hex_acc = 32'd0;
        n_digits = 0;
        got_star = 1'b0;
        got_blank = 1'b0;
        tail_bad = 1'b0;
        first_byte = 1'b1;
    endtask

    task automatic predict_byte(input logic [7:0] c, input logic last);
        logic [4:0] v;
        result_t    r;
        v = digit_value(c);
        if (!(first_byte && c == HASH_CHAR))
        begin
            if (c == STAR_CHAR)
            begin
                crc_star = crc_run;
                got_star = 1'b1;
                hex_acc = 32'd0;
                n_digits = 0;
                got_blank = 1'b0;
                tail_bad = 1'b0;
            end
            else if (got_star && !tail_bad)
            begin
                if (!v[4])
                begin
                    if (got_blank || n_digits >= 8)
                        tail_bad = 1'b1;
                    else
                    begin
                        hex_acc = {hex_acc[27:0], v[3:0]};
                        n_digits++;
                    end
                end
                else if (is_blank_char(c))
                begin
                    if (n_digits < 8)
                        tail_bad = 1'b1;
                    else
                        got_blank = 1'b1;
                end
                else if (!(c == NUL_CHAR && last && n_digits >= 8))
                    tail_bad = 1'b1;
            end
            crc_run = crc_update(crc_run, c);
        end
        first_byte = 1'b0;
        if (last)
        begin
            r = '0;
            if (!got_star)
                r.fault = FAULT_NO_STAR;
            else
            begin
                r.computed_crc = crc_star;
                if (tail_bad || n_digits != 8)
                    r.fault = FAULT_MALFORMED;
                else
                begin
                    r.received_crc = hex_acc;
                    r.fault = (hex_acc == crc_star) ? FAULT_NONE : FAULT_MISMATCH;
                end
            end
            r.checksum_ok = (r.fault == FAULT_NONE);
            expected_results.insert(expected_results.size(), r);
            clear_record_state();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] w, input logic [31:0] g);
        if (w !== g)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, w, g);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[RESULT_W-1:0]);
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result transaction, expected none, actual %h",
                         $time, m_tdata);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("checksum_ok", 32'(want.checksum_ok), 32'(got.checksum_ok));
                check_field("fault", 32'(want.fault), 32'(got.fault));
                check_field("computed_crc", want.computed_crc, got.computed_crc);
                check_field("received_crc", want.received_crc, got.received_crc);
            end
        end
    end

    // Called just after a falling edge; returns just after the falling edge that
    // follows the accepting rising edge, with tvalid left high.
    task automatic send_byte(input logic [7:0] c, input logic last);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_byte(c, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_record();
        for (int i = 0; i < rec_bytes.size(); i++)
            send_byte(rec_bytes[i], i == rec_bytes.size() - 1);
    endtask

    task automatic add_check_digits();
        logic [31:0] c;
        c = 32'd0;
        for (int i = 0; i < rec_bytes.size(); i++)
            if (!(i == 0 && rec_bytes[i] == HASH_CHAR))
                c = crc_update(c, rec_bytes[i]);
        append_byte(STAR_CHAR);
        for (int i = 7; i >= 0; i--)
            append_byte(hex_char(c[i*4 +: 4], 1'($urandom_range(1))));
    endtask

    task automatic test_lone_bytes();
        logic [7:0] lone[4];
        lone = '{HASH_CHAR, NUL_CHAR, 8'hFF, STAR_CHAR};
        for (int i = 0; i < 4; i++)
        begin
            rec_bytes.delete();
            append_byte(lone[i]);
            send_record();
        end
    endtask

    task automatic test_second_hash_and_nul();
        rec_bytes.delete();
        append_byte(HASH_CHAR);
        append_byte(HASH_CHAR);
        add_check_digits();
        append_byte(8'h0D);
        append_byte(NUL_CHAR);
        send_record();
    endtask

    task automatic test_signed_prefix_tail();
        rec_bytes.delete();
        append_byte(STAR_CHAR);
        append_byte(8'h2B);
        append_byte(8'h30);
        append_byte(8'h78);
        send_record();
    endtask

    task automatic test_later_star_mismatch();
        rec_bytes.delete();
        append_byte(STAR_CHAR);
        append_byte(STAR_CHAR);
        for (int i = 0; i < 8; i++)
            append_byte(8'h46);
        send_record();
    endtask

    task automatic test_random_records(input int idle_pct, input int stall_pct, input int n);
        int kind;
        int pos;
        int start;
        logic [4:0] v;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        start = bytes_sent;
        while (bytes_sent - start < n)
        begin
            rec_bytes.delete();
            kind = $urandom_range(99);
            if (kind >= 65 && kind < 78)
            begin
                repeat ($urandom_range(1, 16))
                    append_byte(pick_byte());
            end
            else
            begin
                if ($urandom_range(1))
                    append_byte(HASH_CHAR);
                repeat ($urandom_range(12))
                    append_byte(($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                         : 8'($urandom_range(8'h20, 8'h7E)));
                add_check_digits();
                if ($urandom_range(99) < 15)
                begin
                    pos = rec_bytes.size() - 1 - $urandom_range(7);
                    v = digit_value(rec_bytes[pos]);
                    rec_bytes[pos] = hex_char(v[3:0] ^ 4'($urandom_range(1, 15)),
                                              1'($urandom_range(1)));
                end
                repeat ($urandom_range(3))
                    append_byte(blank_char($urandom_range(5)));
                if ($urandom_range(3) == 0)
                    append_byte(NUL_CHAR);
                if (kind >= 78)
                begin
                    repeat ($urandom_range(1, 2))
                    begin
                        pos = $urandom_range(rec_bytes.size() - 1);
                        case ($urandom_range(2))
                            0: if (rec_bytes.size() > 1) rec_bytes.delete(pos);
                            1: rec_bytes.insert(pos, pick_byte());
                            default: rec_bytes[pos] = pick_byte();
                        endcase
                    end
                end
            end
            send_record();
        end
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_lone_bytes();
        test_second_hash_and_nul();
        test_signed_prefix_tail();
        test_later_star_mismatch();
        test_random_records(0, 0, 350);
        test_random_records(83, 0, 350);
        test_random_records(0, 83, 350);
        test_random_records(30, 30, 350);

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/ascr_pkg.sv
hdl/ascr_core.sv
hdl/ascii_record_crc32_checker.sv
hdl/ascr_checker.sv
verif/tb.sv
